// ===== rtl/core/pfcb_pkg.sv =====
// Shared types and constants of the cubic Bezier path flattener.
`default_nettype none

package pfcb_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned KIND_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN_PATH = 3'd0,
		CMD_END_PATH   = 3'd1,
		CMD_MOVE_TO    = 3'd2,
		CMD_LINE_TO    = 3'd3,
		CMD_CURVE_TO   = 3'd4
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		EV_BEGIN_POLY    = 3'd0,
		EV_BEGIN_CONTOUR = 3'd1,
		EV_VERTEX        = 3'd2,
		EV_END_CONTOUR   = 3'd3,
		EV_END_POLY      = 3'd4
	} ev_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BEGIN_POLY,
		ST_END_CONTOUR,
		ST_END_POLY,
		ST_BEGIN_CONTOUR,
		ST_CURVE,
		ST_VERTEX
	} state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic     issue;
		ev_kind_t kind;
		logic     last;
		logic     zero_wt;
		logic     load_ops;
		logic     prev_load;
		logic     prev_clear;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfcb_if.sv =====
// Valid/ready channel interfaces for path commands and tessellator events.
`default_nettype none

interface pfcb_cmd_if;
	logic                                     valid;
	logic                                     ready;
	logic        [pfcb_pkg::CMD_W-1:0]        cmd;
	logic signed [pfcb_pkg::COORD_W-1:0]      ctrl1_x;
	logic signed [pfcb_pkg::COORD_W-1:0]      ctrl1_y;
	logic signed [pfcb_pkg::COORD_W-1:0]      ctrl2_x;
	logic signed [pfcb_pkg::COORD_W-1:0]      ctrl2_y;
	logic signed [pfcb_pkg::COORD_W-1:0]      end_x;
	logic signed [pfcb_pkg::COORD_W-1:0]      end_y;

	modport source (
		output valid, cmd, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		input  ready
	);
	modport sink (
		input  valid, cmd, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		output ready
	);
endinterface

interface pfcb_evt_if;
	logic                                valid;
	logic                                ready;
	logic        [pfcb_pkg::KIND_W-1:0]  event_kind;
	logic signed [pfcb_pkg::COORD_W-1:0] vertex_x;
	logic signed [pfcb_pkg::COORD_W-1:0] vertex_y;
	logic                                last_of_run;

	modport source (
		output valid, event_kind, vertex_x, vertex_y, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, event_kind, vertex_x, vertex_y, last_of_run,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/pfcb_ctrl.sv =====
// Sequencer: turns each path command into a series of event issue slots.
`default_nettype none

module pfcb_ctrl #(
	parameter int STEPS = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_ready,
	input  wire logic [pfcb_pkg::CMD_W-1:0]        cmd_code,
	input  wire logic                              adv,
	output pfcb_pkg::dp_cmd_t                      ctl,
	output logic [$clog2(STEPS+1)-1:0]             row
);

	localparam int RW = $clog2(STEPS+1);

	pfcb_pkg::state_t         state_q, state_d;
	logic [pfcb_pkg::CMD_W-1:0] cmd_q;
	logic [RW-1:0]            row_q, row_d;
	logic                     open_q, open_d;
	logic                     accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfcb_pkg::ST_IDLE;
			row_q   <= '0;
			open_q  <= 1'b0;
			cmd_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			open_q  <= open_d;
			if (accept) begin
				cmd_q <= cmd_code;
			end
		end
	end

	always_comb begin
		pfcb_pkg::state_t nxt;
		logic             vtx_end;
		logic             clr;

		nxt         = state_q;
		vtx_end     = 1'b0;
		clr         = 1'b0;
		state_d     = state_q;
		row_d       = row_q;
		open_d      = open_q;
		row         = row_q;
		ctl         = '0;
		ctl.kind    = pfcb_pkg::EV_VERTEX;
		ctl.zero_wt = 1'b1;

		unique case (state_q)
			pfcb_pkg::ST_IDLE: begin
				nxt = pfcb_pkg::ST_IDLE;
			end
			pfcb_pkg::ST_BEGIN_POLY: begin
				ctl.kind = pfcb_pkg::EV_BEGIN_POLY;
				ctl.last = 1'b1;
				clr      = 1'b1;
				nxt      = pfcb_pkg::ST_IDLE;
			end
			pfcb_pkg::ST_END_CONTOUR: begin
				ctl.kind = pfcb_pkg::EV_END_CONTOUR;
				if (cmd_q == pfcb_pkg::CMD_END_PATH) begin
					nxt = pfcb_pkg::ST_END_POLY;
				end else begin
					nxt = pfcb_pkg::ST_BEGIN_CONTOUR;
				end
			end
			pfcb_pkg::ST_END_POLY: begin
				ctl.kind = pfcb_pkg::EV_END_POLY;
				ctl.last = 1'b1;
				nxt      = pfcb_pkg::ST_IDLE;
			end
			pfcb_pkg::ST_BEGIN_CONTOUR: begin
				ctl.kind = pfcb_pkg::EV_BEGIN_CONTOUR;
				nxt      = pfcb_pkg::ST_VERTEX;
			end
			pfcb_pkg::ST_CURVE: begin
				ctl.zero_wt = 1'b0;
				if (row_q == RW'(STEPS)) begin
					nxt = pfcb_pkg::ST_VERTEX;
				end else begin
					nxt = pfcb_pkg::ST_CURVE;
				end
			end
			pfcb_pkg::ST_VERTEX: begin
				// The last table row weights only the end point, which gives it exactly.
				ctl.zero_wt = 1'b0;
				ctl.last    = 1'b1;
				row         = RW'(STEPS);
				vtx_end     = 1'b1;
				nxt         = pfcb_pkg::ST_IDLE;
			end
			default: begin
				nxt = pfcb_pkg::ST_IDLE;
			end
		endcase

		ctl.issue      = (state_q != pfcb_pkg::ST_IDLE) && adv;
		ctl.prev_load  = ctl.issue && vtx_end;
		ctl.prev_clear = ctl.issue && clr;
		if (ctl.issue) begin
			state_d = nxt;
			if (state_q == pfcb_pkg::ST_CURVE) begin
				row_d = row_q + RW'(1);
			end
		end

		// A new command may enter in the cycle that issues the last event of the old one.
		cmd_ready    = (state_q == pfcb_pkg::ST_IDLE) || (ctl.issue && ctl.last);
		accept       = cmd_valid && cmd_ready;
		ctl.load_ops = accept;

		if (accept) begin
			row_d = '0;
			unique case (cmd_code)
				pfcb_pkg::CMD_BEGIN_PATH: begin
					state_d = pfcb_pkg::ST_BEGIN_POLY;
					open_d  = 1'b0;
				end
				pfcb_pkg::CMD_END_PATH: begin
					state_d = open_q ? pfcb_pkg::ST_END_CONTOUR : pfcb_pkg::ST_END_POLY;
					open_d  = 1'b0;
				end
				pfcb_pkg::CMD_MOVE_TO: begin
					state_d = open_q ? pfcb_pkg::ST_END_CONTOUR : pfcb_pkg::ST_BEGIN_CONTOUR;
					open_d  = 1'b1;
				end
				pfcb_pkg::CMD_LINE_TO: begin
					state_d = pfcb_pkg::ST_VERTEX;
				end
				pfcb_pkg::CMD_CURVE_TO: begin
					state_d = pfcb_pkg::ST_CURVE;
				end
				default: begin
					state_d = pfcb_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pfcb_datapath.sv =====
// Datapath: operand registers, weight table and the rounded blend pipeline.
`default_nettype none

module pfcb_datapath #(
	parameter int STEPS     = 12,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire pfcb_pkg::dp_cmd_t                      ctl,
	input  wire logic [$clog2(STEPS+1)-1:0]             row,
	input  wire logic signed [pfcb_pkg::COORD_W-1:0]    ctrl1_x,
	input  wire logic signed [pfcb_pkg::COORD_W-1:0]    ctrl1_y,
	input  wire logic signed [pfcb_pkg::COORD_W-1:0]    ctrl2_x,
	input  wire logic signed [pfcb_pkg::COORD_W-1:0]    ctrl2_y,
	input  wire logic signed [pfcb_pkg::COORD_W-1:0]    end_x,
	input  wire logic signed [pfcb_pkg::COORD_W-1:0]    end_y,
	output logic                                        adv,
	pfcb_evt_if.source                                  events
);

	localparam int CW  = pfcb_pkg::COORD_W;
	localparam int WW  = FRAC_BITS + 1;
	localparam int PW  = WW + 1 + CW;
	localparam int AW  = PW + 2;
	localparam int SHW = AW - FRAC_BITS;
	localparam longint unsigned DEN = longint'(STEPS) * longint'(STEPS) * longint'(STEPS);
	localparam logic signed [AW-1:0] BIAS = AW'(1) << (FRAC_BITS - 1);

	// Quantized Bernstein weights, one row per sample index.
	logic [WW-1:0] wtab [STEPS+1][4];

	for (genvar gi = 0; gi <= STEPS; gi++) begin : g_row
		localparam longint unsigned II = longint'(gi);
		localparam longint unsigned UI = longint'(STEPS - gi);
		localparam longint unsigned Q0 = (((UI * UI * UI) << FRAC_BITS) + DEN / 2) / DEN;
		localparam longint unsigned Q1 = (((3 * II * UI * UI) << FRAC_BITS) + DEN / 2) / DEN;
		localparam longint unsigned Q2 = (((3 * II * II * UI) << FRAC_BITS) + DEN / 2) / DEN;
		localparam longint unsigned Q3 = (((II * II * II) << FRAC_BITS) + DEN / 2) / DEN;
		assign wtab[gi][0] = WW'(Q0);
		assign wtab[gi][1] = WW'(Q1);
		assign wtab[gi][2] = WW'(Q2);
		assign wtab[gi][3] = WW'(Q3);
	end

	logic signed [CW-1:0] prev_x_q, prev_y_q;
	logic signed [CW-1:0] c1x_q, c1y_q, c2x_q, c2y_q, ex_q, ey_q;
	logic signed [CW-1:0] op [2][4];
	logic [WW-1:0]        wt [4];

	logic                 v_s1, v_s2, v_s3;
	pfcb_pkg::ev_kind_t   kind_s1, kind_s2, kind_s3;
	logic                 last_s1, last_s2, last_s3;
	logic signed [PW-1:0] prod_s1 [2][4];
	logic signed [PW:0]   pair_s2 [2][2];
	logic signed [CW-1:0] res_s3 [2];
	logic signed [CW-1:0] res_d [2];

	function automatic logic signed [CW-1:0] sat(input logic signed [SHW-1:0] v);
		logic [SHW-CW:0] hi;
		hi = v[SHW-1:CW-1];
		if (&hi || ~|hi) begin
			sat = v[CW-1:0];
		end else if (v[SHW-1]) begin
			sat = {1'b1, {(CW-1){1'b0}}};
		end else begin
			sat = {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (ctl.prev_clear) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (ctl.prev_load) begin
			prev_x_q <= ex_q;
			prev_y_q <= ey_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_ops) begin
			c1x_q <= ctrl1_x;
			c1y_q <= ctrl1_y;
			c2x_q <= ctrl2_x;
			c2y_q <= ctrl2_y;
			ex_q  <= end_x;
			ey_q  <= end_y;
		end
	end

	always_comb begin
		op[0][0] = prev_x_q;
		op[0][1] = c1x_q;
		op[0][2] = c2x_q;
		op[0][3] = ex_q;
		op[1][0] = prev_y_q;
		op[1][1] = c1y_q;
		op[1][2] = c2y_q;
		op[1][3] = ey_q;
		for (int k = 0; k < 4; k++) begin
			wt[k] = ctl.zero_wt ? '0 : wtab[row][k];
		end
	end

	// The whole pipeline moves whenever the output register is free or being drained.
	assign adv = !v_s3 || events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		logic signed [AW-1:0] total;
		for (int a = 0; a < 2; a++) begin
			total    = AW'(pair_s2[a][0]) + AW'(pair_s2[a][1]) + BIAS;
			res_d[a] = sat(total[AW-1:FRAC_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= ctl.kind;
			last_s1 <= ctl.last;
			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			kind_s3 <= kind_s2;
			last_s3 <= last_s2;
			for (int a = 0; a < 2; a++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s1[a][k] <= $signed({1'b0, wt[k]}) * op[a][k];
				end
				pair_s2[a][0] <= (PW+1)'(prod_s1[a][0]) + (PW+1)'(prod_s1[a][1]);
				pair_s2[a][1] <= (PW+1)'(prod_s1[a][2]) + (PW+1)'(prod_s1[a][3]);
				res_s3[a]     <= res_d[a];
			end
		end
	end

	assign events.valid       = v_s3;
	assign events.event_kind  = kind_s3;
	assign events.vertex_x    = res_s3[0];
	assign events.vertex_y    = res_s3[1];
	assign events.last_of_run = last_s3;

endmodule

`default_nettype wire

// ===== rtl/core/path_flattener_cubic_bezier.sv =====
// Path flattener: path commands in, tessellator events out, curves as STEPS+2 vertices.
// An accepted command's events are issued by the sequencer, then pass the product,
// pair-sum and result registers before they are valid. Throughput: one event per cycle
// while the output accepts; a curve issues STEPS+2 events and an unused code none.
// Output back-pressure stalls the blend pipeline and the sequencer together.
// Reset clears the previous point, the open-contour flag and all valid bits at once.
`default_nettype none

module path_flattener_cubic_bezier #(
	parameter int STEPS     = 12,
	parameter int FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pfcb_cmd_if.sink   cmds,
	pfcb_evt_if.source events
);

	localparam int RW = $clog2(STEPS+1);

	pfcb_pkg::dp_cmd_t ctl;
	logic [RW-1:0]     row;
	logic              adv;

	pfcb_ctrl #(
		.STEPS (STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmds.valid),
		.cmd_ready (cmds.ready),
		.cmd_code  (cmds.cmd),
		.adv       (adv),
		.ctl       (ctl),
		.row       (row)
	);

	pfcb_datapath #(
		.STEPS     (STEPS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.row     (row),
		.ctrl1_x (cmds.ctrl1_x),
		.ctrl1_y (cmds.ctrl1_y),
		.ctrl2_x (cmds.ctrl2_x),
		.ctrl2_y (cmds.ctrl2_y),
		.end_x   (cmds.end_x),
		.end_y   (cmds.end_y),
		.adv     (adv),
		.events  (events)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the cubic Bezier path flattener: directed paths, then random paths.
`timescale 1ns / 100ps

module testbench;
	import pfcb_pkg::*;

	localparam int STEPS     = 12;
	localparam int FRAC_BITS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 30;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	localparam logic signed [COORD_W-1:0] COORD_TOP    = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_BOTTOM = 32'sh8000_0000;
	localparam longint SAT_HIGH = 64'sd2147483647;
	localparam longint SAT_LOW  = -SAT_HIGH - 1;
	localparam int NEAR_SPAN = 1000 << FRAC_BITS;

	typedef struct {
		ev_kind_t                   kind;
		logic signed [COORD_W-1:0]  vx;
		logic signed [COORD_W-1:0]  vy;
		logic                       last;
	} tess_event_t;

	logic clk;
	logic arst_n;

	pfcb_cmd_if cmd_bus ();
	pfcb_evt_if evt_bus ();

	path_flattener_cubic_bezier #(
		.STEPS     (STEPS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmds   (cmd_bus),
		.events (evt_bus)
	);

	tess_event_t expected_events[$];
	logic signed [COORD_W-1:0] pen_x;
	logic signed [COORD_W-1:0] pen_y;
	logic contour_live;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int cycle_count;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		evt_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	// Bernstein weight of control point k at sample i, quantized with round half up.
	function automatic longint bernstein_weight(input int k, input int i);
		longint u;
		longint raw;
		longint den;
		u = STEPS - i;
		den = longint'(STEPS) * STEPS * STEPS;
		case (k)
		0: raw = u * u * u;
		1: raw = 3 * i * u * u;
		2: raw = 3 * i * i * u;
		default: raw = longint'(i) * i * i;
		endcase
		return ((raw <<< FRAC_BITS) + den / 2) / den;
	endfunction

	function automatic logic signed [COORD_W-1:0] bezier_sample(input int i,
		input longint p0, input longint p1, input longint p2, input longint p3);
		longint acc;
		acc = bernstein_weight(0, i) * p0 + bernstein_weight(1, i) * p1
			+ bernstein_weight(2, i) * p2 + bernstein_weight(3, i) * p3;
		acc = acc + (longint'(1) <<< (FRAC_BITS - 1));
		// Arithmetic shift floors, so halves round toward plus infinity.
		acc = acc >>> FRAC_BITS;
		if (acc > SAT_HIGH)
			acc = SAT_HIGH;
		if (acc < SAT_LOW)
			acc = SAT_LOW;
		return acc[COORD_W-1:0];
	endfunction

	function automatic void queue_event(input ev_kind_t kind,
		input logic signed [COORD_W-1:0] vx, input logic signed [COORD_W-1:0] vy,
		input logic last);
		tess_event_t ev;
		ev.kind = kind;
		ev.vx = vx;
		ev.vy = vy;
		ev.last = last;
		expected_events.push_back(ev);
	endfunction

	function automatic void flatten_command(input logic [CMD_W-1:0] code,
		input logic signed [COORD_W-1:0] c1x, input logic signed [COORD_W-1:0] c1y,
		input logic signed [COORD_W-1:0] c2x, input logic signed [COORD_W-1:0] c2y,
		input logic signed [COORD_W-1:0] ex, input logic signed [COORD_W-1:0] ey);
		int i;
		case (code)
		CMD_BEGIN_PATH: begin
			queue_event(EV_BEGIN_POLY, '0, '0, 1'b1);
			contour_live = 1'b0;
			pen_x = '0;
			pen_y = '0;
		end
		CMD_END_PATH: begin
			if (contour_live)
				queue_event(EV_END_CONTOUR, '0, '0, 1'b0);
			queue_event(EV_END_POLY, '0, '0, 1'b1);
			contour_live = 1'b0;
		end
		CMD_MOVE_TO: begin
			if (contour_live)
				queue_event(EV_END_CONTOUR, '0, '0, 1'b0);
			queue_event(EV_BEGIN_CONTOUR, '0, '0, 1'b0);
			queue_event(EV_VERTEX, ex, ey, 1'b1);
			contour_live = 1'b1;
			pen_x = ex;
			pen_y = ey;
		end
		CMD_LINE_TO: begin
			queue_event(EV_VERTEX, ex, ey, 1'b1);
			pen_x = ex;
			pen_y = ey;
		end
		CMD_CURVE_TO: begin
			for (i = 0; i <= STEPS; i++)
				queue_event(EV_VERTEX, bezier_sample(i, pen_x, c1x, c2x, ex),
					bezier_sample(i, pen_y, c1y, c2y, ey), 1'b0);
			queue_event(EV_VERTEX, ex, ey, 1'b1);
			pen_x = ex;
			pen_y = ey;
		end
		default: begin
		end
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays high between back-to-back beats.
	task automatic send_path(input logic [CMD_W-1:0] code,
		input logic signed [COORD_W-1:0] ex = '0, input logic signed [COORD_W-1:0] ey = '0,
		input logic signed [COORD_W-1:0] c1x = '0, input logic signed [COORD_W-1:0] c1y = '0,
		input logic signed [COORD_W-1:0] c2x = '0, input logic signed [COORD_W-1:0] c2y = '0);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid   <= 1'b1;
		cmd_bus.cmd     <= code;
		cmd_bus.ctrl1_x <= c1x;
		cmd_bus.ctrl1_y <= c1y;
		cmd_bus.ctrl2_x <= c2x;
		cmd_bus.ctrl2_y <= c2y;
		cmd_bus.end_x   <= ex;
		cmd_bus.end_y   <= ey;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		flatten_command(code, c1x, c1y, c2x, c2y, ex, ey);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_events
		tess_event_t want;
		if (arst_n && evt_bus.valid && evt_bus.ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d (%0d, %0d)",
					evt_bus.event_kind, evt_bus.vertex_x, evt_bus.vertex_y));
			end else begin
				want = expected_events.pop_front();
				if (evt_bus.event_kind !== want.kind)
					report_mismatch($sformatf("event_kind %0d, expected %0d",
						evt_bus.event_kind, want.kind));
				if (evt_bus.vertex_x !== want.vx)
					report_mismatch($sformatf("vertex_x %0d, expected %0d",
						evt_bus.vertex_x, want.vx));
				if (evt_bus.vertex_y !== want.vy)
					report_mismatch($sformatf("vertex_y %0d, expected %0d",
						evt_bus.vertex_y, want.vy));
				if (evt_bus.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %b, expected %b",
						evt_bus.last_of_run, want.last));
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
		8: return COORD_TOP;
		9: return COORD_BOTTOM;
		5, 6, 7: return $urandom_range(2 * NEAR_SPAN) - NEAR_SPAN;
		default: return $urandom;
		endcase
	endfunction

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	// Curves and lines are legal with nothing open; the first curve starts at the origin.
	task automatic test_nothing_open();
		send_path(CMD_CURVE_TO, 32'sd300000, -32'sd200000,
			32'sd100000, 32'sd50000, -32'sd70000, 32'sd90000);
		send_path(CMD_LINE_TO, -32'sd12345, 32'sd67890);
	endtask

	task automatic test_path_structure();
		send_path(CMD_BEGIN_PATH);
		send_path(CMD_MOVE_TO, 32'sd65536, 32'sd131072);
		send_path(CMD_LINE_TO, 32'sd196608, -32'sd65536);
		// A second move closes the open contour first.
		send_path(CMD_MOVE_TO, -32'sd1, 32'sd1);
		send_path(CMD_END_PATH);
		send_path(CMD_END_PATH);
		send_path(CMD_BEGIN_PATH);
		send_path(CMD_MOVE_TO, 32'sd42, 32'sd43);
		// Begin path drops an open contour without closing it.
		send_path(CMD_BEGIN_PATH);
		send_path(CMD_MOVE_TO, 32'sd7, -32'sd7);
	endtask

	task automatic test_extreme_curves();
		send_path(CMD_MOVE_TO, COORD_TOP, COORD_TOP);
		send_path(CMD_CURVE_TO, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
		send_path(CMD_LINE_TO, COORD_BOTTOM, COORD_BOTTOM);
		send_path(CMD_CURVE_TO, COORD_BOTTOM, COORD_BOTTOM,
			COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM);
		send_path(CMD_CURVE_TO, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP,
			COORD_TOP, COORD_BOTTOM);
		// Tiny coordinates put many sums exactly on a rounding half.
		send_path(CMD_LINE_TO, 32'sd1, -32'sd1);
		send_path(CMD_CURVE_TO, 32'sd3, -32'sd3, 32'sd1, -32'sd1, -32'sd1, 32'sd1);
		send_path(CMD_END_PATH);
	endtask

	task automatic test_unused_codes();
		logic [CMD_W-1:0] code;
		for (code = CMD_UNUSED_FIRST; code != CMD_UNUSED_FIRST - 1; code++) begin
			send_path(code, COORD_TOP, COORD_BOTTOM, COORD_TOP, COORD_BOTTOM,
				COORD_TOP, COORD_BOTTOM);
			if (code == CMD_UNUSED_LAST)
				break;
		end
		// The previous point must be untouched by the ignored codes.
		send_path(CMD_CURVE_TO, 32'sd1000, 32'sd2000, 32'sd3000, 32'sd4000, 32'sd5000, 32'sd6000);
	endtask

	task automatic test_random_paths(input int quota);
		int sent;
		int n_contours;
		int n_segments;
		logic [CMD_W-1:0] code;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 15) begin
				code = $urandom_range(CMD_UNUSED_LAST);
				send_path(code, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord());
				if (code <= CMD_CURVE_TO)
					sent++;
			end else begin
				send_path(CMD_BEGIN_PATH);
				sent++;
				n_contours = $urandom_range(1, 3);
				repeat (n_contours) begin
					send_path(CMD_MOVE_TO, rand_coord(), rand_coord());
					sent++;
					n_segments = $urandom_range(1, 4);
					repeat (n_segments) begin
						if ($urandom_range(1))
							send_path(CMD_LINE_TO, rand_coord(), rand_coord());
						else
							send_path(CMD_CURVE_TO, rand_coord(), rand_coord(), rand_coord(),
								rand_coord(), rand_coord(), rand_coord());
						sent++;
					end
				end
				// Now and then a path is left without its end.
				if ($urandom_range(9) != 0) begin
					send_path(CMD_END_PATH);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		fail_count = 0;
		pen_x = '0;
		pen_y = '0;
		contour_live = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.cmd = CMD_BEGIN_PATH;
		cmd_bus.ctrl1_x = '0;
		cmd_bus.ctrl1_y = '0;
		cmd_bus.ctrl2_x = '0;
		cmd_bus.ctrl2_y = '0;
		cmd_bus.end_x = '0;
		cmd_bus.end_y = '0;
		evt_bus.ready = 1'b0;
		set_idling(35, 75);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_nothing_open();
		test_path_structure();
		test_extreme_curves();
		test_unused_codes();
		test_random_paths(55);
		set_idling(75, 35);
		test_random_paths(55);
		set_idling(0, 0);
		test_random_paths(55);

		cmd_bus.valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", expected_events.size()));

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
